@@ design/pee_pkg.sv @@
// Shared constants and the sequencer state type for the postfix expression evaluator.
`default_nettype none
package pee_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;
	localparam int WORD_W = 32;
	localparam int SYM_W = 8;
	localparam int DIV_STEPS = WORD_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_TIMES = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

	localparam logic [WORD_W-1:0] EMPTY_VALUE = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_A,
		ST_POP_B,
		ST_EXEC,
		ST_DIV,
		ST_DPUSH,
		ST_TOP,
		ST_EMIT
	} seq_state_t;

endpackage
`default_nettype wire

@@ design/postfix_expression_evaluator.sv @@
// Postfix expression evaluator: operand stack in a memory, a serial divider, one sequencer.
// Per transfer: a digit is pushed while the sequencer is idle; + - * and any other symbol pass through
// POP_A, POP_B and EXEC; a division adds DIV (the bit-serial restoring divider) and DPUSH, skipped on a zero divisor.
// A transfer marked last adds TOP to pop the top and EMIT to load the output register; EMIT waits on a stalled output.
// The stack memory has one read port, so each pop takes its own state.
// Reset clears the stack depth, the sticky flags, the sequencer and the output valid.
`default_nettype none
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pee_pkg::DEFAULT_STACK_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // Bits 7:0 symbol.
	input  wire logic        s_axis_tlast,   // The last field.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // Bits 31:0 value.
	output logic [1:0]       m_axis_tuser    // Bit 0 div_zero_seen, bit 1 overflow_seen.
);
	import pee_pkg::*;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	seq_state_t state_q, state_d;

	logic [WORD_W-1:0] mem [STACK_DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [DEPTH_W-1:0] depth_q;
	logic div_zero_q, overflow_q;
	logic [SYM_W-1:0] sym_q;
	logic last_q;
	logic empty_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] quo_q, rem_q, dvs_q;
	logic neg_q;
	logic [STEP_W-1:0] cnt_q;
	logic out_valid_q, out_dz_q, out_ov_q;
	logic [WORD_W-1:0] out_value_q;

	logic accept, is_digit, depth_zero, stack_full;
	logic push_req, pop_req, rd_en;
	logic [WORD_W-1:0] push_val;
	logic [IDX_W-1:0] top_idx;
	logic [WORD_W-1:0] b_val, un, ud;
	logic [WORD_W:0] shifted;
	logic [WORD_W+1:0] diff;
	logic div_last_step, out_free, op_simple, div_by_zero;
	logic [WORD_W-1:0] product;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_digit = (s_axis_tdata >= SYM_ZERO) && (s_axis_tdata <= SYM_NINE);
	assign depth_zero = (depth_q == '0);
	assign stack_full = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign top_idx = IDX_W'(depth_q - DEPTH_W'(1));
	assign b_val = empty_q ? EMPTY_VALUE : rd_q;
	assign product = b_val * a_q;
	assign un = b_val[WORD_W-1] ? (WORD_W'(0) - b_val) : b_val;
	assign ud = a_q[WORD_W-1] ? (WORD_W'(0) - a_q) : a_q;
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};
	assign div_last_step = (cnt_q == STEP_W'(DIV_STEPS - 1));
	assign out_free = !out_valid_q || m_axis_tready;
	assign op_simple = (sym_q == SYM_PLUS) || (sym_q == SYM_MINUS) || (sym_q == SYM_TIMES);
	assign div_by_zero = (sym_q == SYM_SLASH) && (a_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!is_digit) begin
						state_d = ST_POP_A;
					end else if (s_axis_tlast) begin
						state_d = ST_TOP;
					end
				end
			end
			ST_POP_A: state_d = ST_POP_B;
			ST_POP_B: state_d = ST_EXEC;
			ST_EXEC: begin
				if ((sym_q == SYM_SLASH) && (a_q != '0)) begin
					state_d = ST_DIV;
				end else if (last_q) begin
					state_d = ST_TOP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_last_step) begin
					state_d = ST_DPUSH;
				end
			end
			ST_DPUSH: state_d = last_q ? ST_TOP : ST_IDLE;
			ST_TOP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		push_req = 1'b0;
		push_val = '0;
		pop_req = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				push_req = s_axis_tvalid && is_digit;
				push_val = {{(WORD_W - SYM_W){1'b0}}, s_axis_tdata - SYM_ZERO};
			end
			ST_POP_A, ST_POP_B, ST_TOP: begin
				pop_req = !depth_zero;
				rd_en = !depth_zero;
			end
			ST_EXEC: begin
				push_req = op_simple || div_by_zero;
				if (sym_q == SYM_PLUS) begin
					push_val = b_val + a_q;
				end else if (sym_q == SYM_MINUS) begin
					push_val = b_val - a_q;
				end else if (sym_q == SYM_TIMES) begin
					push_val = product;
				end else begin
					push_val = '0;
				end
			end
			ST_DPUSH: begin
				push_req = 1'b1;
				push_val = neg_q ? (WORD_W'(0) - quo_q) : quo_q;
			end
			default: begin
				push_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_req && !stack_full) begin
			mem[depth_q[IDX_W-1:0]] <= push_val;
		end
		if (rd_en) begin
			rd_q <= mem[top_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			div_zero_q <= 1'b0;
			overflow_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push_req) begin
				if (stack_full) begin
					overflow_q <= 1'b1;
				end else begin
					depth_q <= depth_q + DEPTH_W'(1);
				end
			end else if (pop_req) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
			if ((state_q == ST_EXEC) && div_by_zero) begin
				div_zero_q <= 1'b1;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
				depth_q <= '0;
				div_zero_q <= 1'b0;
				overflow_q <= 1'b0;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sym_q <= s_axis_tdata;
					last_q <= s_axis_tlast;
				end
			end
			ST_POP_A, ST_TOP: begin
				empty_q <= depth_zero;
			end
			ST_POP_B: begin
				a_q <= empty_q ? EMPTY_VALUE : rd_q;
				empty_q <= depth_zero;
			end
			ST_EXEC: begin
				quo_q <= un;
				dvs_q <= ud;
				rem_q <= '0;
				neg_q <= b_val[WORD_W-1] ^ a_q[WORD_W-1];
				cnt_q <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (!diff[WORD_W+1]) begin
					rem_q <= diff[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b0};
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_value_q <= empty_q ? EMPTY_VALUE : rd_q;
					out_dz_q <= div_zero_q;
					out_ov_q <= overflow_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_value_q;
	assign m_axis_tuser = {out_ov_q, out_dz_q};

endmodule
`default_nettype wire

@@ bench/postfix_expression_evaluator_test.sv @@
// Self-checking testbench that streams postfix expressions into the evaluator and checks each result.
`timescale 1ns / 1ps
module postfix_expression_evaluator_test;
	import pee_pkg::*;

	localparam int STACK_SIZE = DEFAULT_STACK_DEPTH;
	localparam int RANDOM_SYMBOLS = 700;
	localparam int CALM_TAIL = 80;
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [SYM_W-1:0] symbol;
		logic             last;
		bit               drain_first;
	} symbol_item_t;

	typedef struct {
		logic [WORD_W-1:0] value;
		logic              div_zero_seen;
		logic              overflow_seen;
	} expr_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;
	logic [1:0]        m_axis_tuser;

	symbol_item_t      pending_symbols[$];
	expr_result_t      awaited_results[$];
	symbol_item_t      upcoming;
	expr_result_t      wanted;

	logic [WORD_W-1:0] operands [STACK_SIZE];
	int unsigned       operand_count = 0;
	bit                div_zero_sticky = 1'b0;
	bit                overflow_sticky = 1'b0;

	int symbols_total = 0;
	int symbols_sent = 0;
	int expressions_sent = 0;
	int results_seen = 0;
	int div_zero_results = 0;
	int overflow_results = 0;
	int errors = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit recv_hold = 1'b0;

	postfix_expression_evaluator #(
		.STACK_DEPTH(STACK_SIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	function automatic void push_operand(logic [WORD_W-1:0] v);
		if (operand_count >= STACK_SIZE) begin
			overflow_sticky = 1'b1;
		end else begin
			operands[operand_count] = v;
			operand_count++;
		end
	endfunction

	function automatic logic [WORD_W-1:0] pop_operand();
		if (operand_count == 0)
			return EMPTY_VALUE;
		operand_count--;
		return operands[operand_count];
	endfunction

	function automatic logic [WORD_W-1:0] divide_toward_zero(logic [WORD_W-1:0] n,
			logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] un, ud, q;
		un = n[WORD_W-1] ? -n : n;
		ud = d[WORD_W-1] ? -d : d;
		q = un / ud;
		return (n[WORD_W-1] != d[WORD_W-1]) ? -q : q;
	endfunction

	function automatic void evaluate_symbol(logic [SYM_W-1:0] sym, logic last);
		logic [WORD_W-1:0] a, b;
		expr_result_t res;
		if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
			push_operand(WORD_W'(sym - SYM_ZERO));
		end else begin
			a = pop_operand();
			b = pop_operand();
			case (sym)
				SYM_PLUS: push_operand(b + a);
				SYM_MINUS: push_operand(b - a);
				SYM_TIMES: push_operand(b * a);
				SYM_SLASH: begin
					if (a == '0) begin
						div_zero_sticky = 1'b1;
						push_operand('0);
					end else begin
						push_operand(divide_toward_zero(b, a));
					end
				end
				default: ;
			endcase
		end
		if (last) begin
			res.value = pop_operand();
			res.div_zero_seen = div_zero_sticky;
			res.overflow_seen = overflow_sticky;
			awaited_results.push_back(res);
			operand_count = 0;
			div_zero_sticky = 1'b0;
			overflow_sticky = 1'b0;
			expressions_sent++;
		end
	endfunction

	function automatic void add_symbol(logic [SYM_W-1:0] sym, logic last);
		symbol_item_t item;
		item.symbol = sym;
		item.last = last;
		item.drain_first = 1'b0;
		pending_symbols.push_back(item);
	endfunction

	function automatic void add_expression(string text);
		for (int i = 0; i < text.len(); i++)
			add_symbol(text[i], i == text.len() - 1);
	endfunction

	function automatic logic [SYM_W-1:0] any_digit();
		return SYM_ZERO + SYM_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [SYM_W-1:0] any_operator();
		case ($urandom_range(0, 3))
			0: return SYM_PLUS;
			1: return SYM_MINUS;
			2: return SYM_TIMES;
			default: return SYM_SLASH;
		endcase
	endfunction

	function automatic int add_random_expression();
		int operand_goal, pushed, held, count;
		bit front_load;
		logic [SYM_W-1:0] sym;
		count = 0;
		if ($urandom_range(0, 4) == 0) begin
			// Noise and broken expressions: any byte, unbalanced operators.
			count = $urandom_range(1, 10);
			for (int i = 0; i < count; i++) begin
				case ($urandom_range(0, 2))
					0: sym = SYM_W'($urandom_range(0, 255));
					1: sym = any_digit();
					default: sym = any_operator();
				endcase
				add_symbol(sym, i == count - 1);
			end
			return count;
		end
		operand_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
		front_load = operand_goal > 14;
		pushed = 0;
		held = 0;
		while (pushed < operand_goal || held > 1) begin
			if (held < 2 || (pushed < operand_goal && (front_load || $urandom_range(0, 1) == 1))) begin
				sym = any_digit();
				pushed++;
				held++;
			end else begin
				sym = any_operator();
				held--;
			end
			add_symbol(sym, pushed == operand_goal && held == 1);
			count++;
		end
		return count;
	endfunction

	initial begin
		int added;
		int first_random;
		add_expression("7");
		add_symbol(8'hFF, 1'b1);
		add_symbol(8'h00, 1'b0);
		add_expression("5");
		add_expression("+");
		add_expression("90/");
		add_expression("95-");
		add_expression("63*");
		add_expression("27-3/");
		// Builds the most negative value, then divides it by minus one.
		add_expression("+8*8*8*8*8*8*8*8*8*8*01-/");
		add_expression("98765432109876543");
		first_random = pending_symbols.size();
		added = 0;
		while (added < RANDOM_SYMBOLS)
			added += add_random_expression();
		pending_symbols[first_random].drain_first = 1'b1;
		symbols_total = pending_symbols.size();
	end

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				evaluate_symbol(s_axis_tdata, s_axis_tlast);
				symbols_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_symbols.size() > 0 &&
						!(pending_symbols[0].drain_first && awaited_results.size() > 0)) begin
					upcoming = pending_symbols.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= upcoming.symbol;
					s_axis_tlast <= upcoming.last;
					if (symbols_sent < symbols_total - CALM_TAIL && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 9);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer, expected none, actual value %h flags %b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					wanted = awaited_results.pop_front();
					if (m_axis_tdata !== wanted.value) begin
						errors++;
						$display("%0t: value mismatch, expected %h, actual %h",
							$time, wanted.value, m_axis_tdata);
					end
					if (m_axis_tuser[0] !== wanted.div_zero_seen) begin
						errors++;
						$display("%0t: div_zero_seen mismatch, expected %b, actual %b",
							$time, wanted.div_zero_seen, m_axis_tuser[0]);
					end
					if (m_axis_tuser[1] !== wanted.overflow_seen) begin
						errors++;
						$display("%0t: overflow_seen mismatch, expected %b, actual %b",
							$time, wanted.overflow_seen, m_axis_tuser[1]);
					end
					div_zero_results += wanted.div_zero_seen;
					overflow_results += wanted.overflow_seen;
				end
			end
			if (recv_hold) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (symbols_sent < symbols_total - CALM_TAIL && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 9);
			end
		end
	end

	initial begin
		wait (symbols_sent >= HOLD_AFTER);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Run timed out with %0d results still awaited.", awaited_results.size());
		$display("[postfix_expression_evaluator] ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_symbols.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (awaited_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Streamed %0d symbols in %0d expressions and checked %0d results.",
			symbols_sent, expressions_sent, results_seen);
		$display("Of those, %0d reported a division by zero and %0d a stack overflow.",
			div_zero_results, overflow_results);
		if (errors == 0)
			$display("[postfix_expression_evaluator] OK");
		else
			$display("[postfix_expression_evaluator] ERROR");
		$finish;
	end

endmodule
